### rtl/core/dfs_pkg.sv
// Shared types, constants and register codes for the delimited field selector.
`timescale 1ns / 1ps

package dfs_pkg;

  localparam int NUM_DELIMS   = 4;
  localparam int INDEX_BITS   = 16;
  localparam int DELIM_REGS   = 4;
  localparam int DELIM_LIMIT  = (NUM_DELIMS < DELIM_REGS) ? NUM_DELIMS : DELIM_REGS;
  localparam int UNIT_W       = 16;
  localparam int CMP_W        = (INDEX_BITS > UNIT_W) ? INDEX_BITS : UNIT_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [1:0] MODE_EXTRACT = 2'd0;
  localparam logic [1:0] MODE_COUNT   = 2'd1;
  localparam logic [1:0] MODE_REMOVE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_A     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_B     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_C     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_D     = 3'd7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              has_byte;
    logic              is_last;
    logic [UNIT_W-1:0] unit_total;
  } out_word_t;

  typedef struct packed {
    logic [1:0]                       mode;
    logic [UNIT_W-1:0]                first_unit;
    logic [UNIT_W-1:0]                last_unit;
    logic [2:0]                       delim_count;
    logic [DELIM_REGS-1:0][7:0]       delim;
  } cfg_t;

endpackage

### rtl/core/dfs_datapath.sv
// Per-word unit tracking state and the result logic for one text word.
`timescale 1ns / 1ps

module dfs_datapath (
  input  logic             clk,
  input  logic             rst,
  input  dfs_pkg::cfg_t    cfg,
  input  dfs_pkg::in_word_t item,
  input  logic             fire,
  output logic             emit,
  output dfs_pkg::out_word_t result
);

  localparam logic [dfs_pkg::INDEX_BITS-1:0] IDX_MAX  = '1;
  localparam logic [dfs_pkg::UNIT_W-1:0]     TALLY_MAX = '1;

  logic [dfs_pkg::INDEX_BITS-1:0] unit_index, unit_index_next;
  logic [7:0]                     held_delim, held_delim_next;
  logic                           held_valid, held_valid_next;
  logic                           saw_content, saw_content_next;
  logic [dfs_pkg::UNIT_W-1:0]     unit_tally, unit_tally_next;

  logic                           is_delim;
  logic [3:0]                     delim_used;
  logic [dfs_pkg::CMP_W-1:0]      idx_ext, first_ext, last_ext;
  logic [dfs_pkg::CMP_W:0]        idx_plus;
  logic [dfs_pkg::INDEX_BITS-1:0] idx_bumped;

  // Active delimiter count, clamped to what the hardware holds.
  always_comb begin
    if (cfg.delim_count > 3'(dfs_pkg::DELIM_LIMIT)) begin
      delim_used = 4'(dfs_pkg::DELIM_LIMIT);
    end else begin
      delim_used = {1'b0, cfg.delim_count};
    end
  end

  always_comb begin
    is_delim = 1'b0;
    for (int i = 0; i < dfs_pkg::DELIM_REGS; i++) begin
      if ((4'(i) < delim_used) && (cfg.delim[i] == item.in_byte)) begin
        is_delim = 1'b1;
      end
    end
  end

  assign idx_ext    = dfs_pkg::CMP_W'(unit_index);
  assign first_ext  = dfs_pkg::CMP_W'(cfg.first_unit);
  assign last_ext   = dfs_pkg::CMP_W'(cfg.last_unit);
  assign idx_plus   = {1'b0, idx_ext} + 1'b1;
  assign idx_bumped = (unit_index == IDX_MAX) ? unit_index : unit_index + 1'b1;

  always_comb begin
    unit_index_next  = unit_index;
    held_delim_next  = held_delim;
    held_valid_next  = held_valid;
    saw_content_next = saw_content;
    unit_tally_next  = unit_tally;
    emit             = 1'b0;
    result           = '0;

    if (item.is_end) begin
      emit           = 1'b1;
      result.is_last = 1'b1;
      if (cfg.mode == dfs_pkg::MODE_COUNT) begin
        result.unit_total = unit_tally;
        if (saw_content && (unit_tally != TALLY_MAX)) begin
          result.unit_total = unit_tally + 1'b1;
        end
      end
      unit_index_next  = '0;
      held_delim_next  = '0;
      held_valid_next  = 1'b0;
      saw_content_next = 1'b0;
      unit_tally_next  = '0;
    end else begin
      unique case (cfg.mode)
        dfs_pkg::MODE_EXTRACT: begin
          if ((idx_ext >= first_ext) && (idx_ext <= last_ext) &&
              (!is_delim || (idx_ext < last_ext))) begin
            emit            = 1'b1;
            result.out_byte = item.in_byte;
          end
          if (is_delim) begin
            unit_index_next = idx_bumped;
          end
        end
        dfs_pkg::MODE_COUNT: begin
          if (is_delim) begin
            if (unit_tally != TALLY_MAX) begin
              unit_tally_next = unit_tally + 1'b1;
            end
            saw_content_next = 1'b0;
          end else begin
            saw_content_next = 1'b1;
          end
        end
        dfs_pkg::MODE_REMOVE: begin
          if (is_delim) begin
            if (idx_ext < first_ext) begin
              if (idx_plus == {1'b0, first_ext}) begin
                // Delimiter ahead of the doomed unit: hold it back in case
                // that unit turns out to be the final one.
                held_delim_next = item.in_byte;
                held_valid_next = 1'b1;
              end else begin
                emit            = 1'b1;
                result.out_byte = item.in_byte;
              end
            end else if (idx_ext == first_ext) begin
              if (held_valid) begin
                emit            = 1'b1;
                result.out_byte = held_delim;
                held_valid_next = 1'b0;
                held_delim_next = '0;
              end
            end else begin
              emit            = 1'b1;
              result.out_byte = item.in_byte;
            end
            unit_index_next = idx_bumped;
          end else if (idx_ext != first_ext) begin
            emit            = 1'b1;
            result.out_byte = item.in_byte;
          end
        end
        default: begin
        end
      endcase
      result.has_byte = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_index  <= '0;
      held_delim  <= '0;
      held_valid  <= 1'b0;
      saw_content <= 1'b0;
      unit_tally  <= '0;
    end else if (fire) begin
      unit_index  <= unit_index_next;
      held_delim  <= held_delim_next;
      held_valid  <= held_valid_next;
      saw_content <= saw_content_next;
      unit_tally  <= unit_tally_next;
    end
  end

endmodule

### rtl/core/dfs_out_buf.sv
// Two-entry result queue: an output register with a skid entry behind it.
`timescale 1ns / 1ps

module dfs_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dfs_pkg::out_word_t din,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output dfs_pkg::out_word_t out_word
);

  dfs_pkg::out_word_t word0, word1;
  logic               valid0, valid1;
  logic               pop;

  assign pop       = valid0 && out_ready;
  assign space     = !valid1 || pop;
  assign out_valid = valid0;
  assign out_word  = word0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else begin
      if (pop && push) begin
        if (valid1) begin
          word0 <= word1;
          word1 <= din;
        end else begin
          word0 <= din;
        end
      end else if (pop) begin
        word0  <= word1;
        valid0 <= valid1;
        valid1 <= 1'b0;
      end else if (push) begin
        if (!valid0) begin
          word0  <= din;
          valid0 <= 1'b1;
        end else begin
          word1  <= din;
          valid1 <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/delimited_field_selector_top.sv
// Top level of the delimited field selector: configuration, input register and result queue.
`timescale 1ns / 1ps
// A word accepted into the input register is processed combinationally and its result is
// registered in the result queue, which drives out_word. Throughput: one input word per cycle
// unless a result waits on a full queue; a word that gives no result still takes its cycle.
// Reset (rst, synchronous, active high) empties the input register and result queue, clears
// the unit tracking state and returns every configuration register to its reset value.

module delimited_field_selector_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dfs_pkg::in_word_t                in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dfs_pkg::out_word_t               out_word,
  input  logic                             cfg_we,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers. Software writes them only while the block is idle (the block itself
  // does not enforce this), so they feed the datapath directly without any shadowing.
  dfs_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= dfs_pkg::MODE_EXTRACT;
      cfg.first_unit  <= '0;
      cfg.last_unit   <= '0;
      cfg.delim_count <= 3'd1;
      cfg.delim[0]    <= 8'd32;
      cfg.delim[1]    <= 8'd9;
      cfg.delim[2]    <= 8'd10;
      cfg.delim[3]    <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfs_pkg::REG_MODE:        cfg.mode        <= cfg_data[1:0];
        dfs_pkg::REG_FIRST_UNIT:  cfg.first_unit  <= cfg_data[dfs_pkg::UNIT_W-1:0];
        dfs_pkg::REG_LAST_UNIT:   cfg.last_unit   <= cfg_data[dfs_pkg::UNIT_W-1:0];
        dfs_pkg::REG_DELIM_COUNT: cfg.delim_count <= cfg_data[2:0];
        dfs_pkg::REG_DELIM_A:     cfg.delim[0]    <= cfg_data[7:0];
        dfs_pkg::REG_DELIM_B:     cfg.delim[1]    <= cfg_data[7:0];
        dfs_pkg::REG_DELIM_C:     cfg.delim[2]    <= cfg_data[7:0];
        dfs_pkg::REG_DELIM_D:     cfg.delim[3]    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register. The word held here is processed in a single pass and retires when the
  // result queue can take its result, or at once when it produces none.
  dfs_pkg::in_word_t  held_word;
  logic               held_valid;
  logic               emit;
  logic               space;
  logic               advance;
  dfs_pkg::out_word_t result;

  assign advance  = held_valid && (!emit || space);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_word <= in_word;
    end
  end

  // Delimiter match, unit counting and mode selection for the held word.
  dfs_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (held_word),
    .fire   (advance),
    .emit   (emit),
    .result (result)
  );

  // The skid entry lets the input side keep moving while a result waits on out_ready.
  dfs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && emit),
    .din       (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

### rtl/core/dfs_checker.sv
// Port-level checks for the delimited field selector, bound to its top level.
`timescale 1ns / 1ps

module dfs_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input dfs_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed or dropped while stalled");

  a_last_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.is_last |-> !out_word.has_byte && (out_word.out_byte == 8'd0))
    else $error("terminator result carries a text byte");

  a_byte_or_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.has_byte || out_word.is_last)
    else $error("result word carries neither a byte nor the terminator");

  a_total_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.is_last |-> (out_word.unit_total == '0))
    else $error("unit total reported on a byte result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result queue not empty after reset");

endmodule

bind delimited_field_selector_top dfs_checker u_dfs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
